[rtl/core/ptl_pkg.sv]
// Shared types and constants for the pedestrian traffic light controller.
// Used by every module under rtl/core; no dependencies of its own.
package ptl_pkg;

  localparam int unsigned TimeBits    = 32;
  localparam int unsigned SampleBits  = 12;
  localparam int unsigned LampBits    = 8;
  localparam int unsigned MsBits      = 16;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned BlinkMs     = 500;

  localparam int unsigned InDataBits  = ((TimeBits + SampleBits + 7) / 8) * 8;
  localparam int unsigned OutRawBits  = 2 * LampBits + 2 + SampleBits;
  localparam int unsigned OutDataBits = ((OutRawBits + 7) / 8) * 8;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DARK_THRESHOLD = 3'd0,
    CFG_DEBOUNCE_MS    = 3'd1,
    CFG_AMBER_MS       = 3'd2,
    CFG_CROSSING_MS    = 3'd3,
    CFG_LAMP_LEVEL     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_NIGHT  = 2'd0,
    PH_GREEN  = 2'd1,
    PH_YELLOW = 2'd2,
    PH_RED    = 2'd3
  } phase_e;

  typedef enum logic {
    OP_BUTTON = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef struct packed {
    logic [SampleBits-1:0] dark_threshold;
    logic [MsBits-1:0]     debounce_ms;
    logic [MsBits-1:0]     amber_ms;
    logic [MsBits-1:0]     crossing_ms;
    logic [LampBits-1:0]   lamp_level;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    logic [TimeBits-1:0]   now_ms;
    logic [SampleBits-1:0] light_sample;
  } item_t;

  typedef struct packed {
    logic [SampleBits-1:0] light_seen;
    logic                  crossing_active;
    logic                  night_mode;
    logic [LampBits-1:0]   lamp_green;
    logic [LampBits-1:0]   lamp_red;
  } result_t;

endpackage

[rtl/core/pedestrian_traffic_light_fsm_core.sv]
// Top level of the pedestrian traffic light controller.
// Depends on ptl_pkg, ptl_cfg and ptl_fsm.
//
// Usage:
//   s_axis carries input items: tuser[0] is op (0 button edge, 1 update),
//   tdata holds now_ms and light_sample. A button item yields no result;
//   an update item yields one result item on m_axis.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the block is idle; indexes beyond the register list are ignored.
// Timing:
//   An accepted item waits in the input register until it fires; then the
//   phase logic updates the state and, for an update, loads the result
//   register that drives m_axis_tvalid. One item per cycle is sustained
//   unless an update stalls; the limit is the single state update per cycle.
// Reset:
//   Both registers empty, phase green, no request, timestamps zero,
//   configuration registers at their defaults.
// Stall:
//   While m_axis_tready is low with a result waiting, an update in the input
//   register waits and s_axis_tready drops; button items still pass.
module pedestrian_traffic_light_fsm_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptl_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [ptl_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] now_ms, [43:32] light_sample, [47:44] unused
  input  logic [ptl_pkg::InDataBits-1:0]   s_axis_tdata,
  // [0] op
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] lamp_red, [15:8] lamp_green, [16] night_mode, [17] crossing_active,
  // [29:18] light_seen, [31:30] zero
  output logic [ptl_pkg::OutDataBits-1:0]  m_axis_tdata
);
  import ptl_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t result_c, result_q;
  logic    out_valid_q;
  logic    out_room, fire, is_update;

  assign is_update     = item_q.op == OP_UPDATE;
  assign out_room      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!is_update || out_room);
  assign s_axis_tready = !in_valid_q || fire;

  ptl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  ptl_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.op           <= op_e'(s_axis_tuser[0]);
      item_q.now_ms       <= s_axis_tdata[TimeBits-1:0];
      item_q.light_sample <= s_axis_tdata[TimeBits+SampleBits-1:TimeBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_room) begin
      out_valid_q <= fire && is_update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_update) begin
      result_q <= result_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataBits'(result_q);

endmodule

[rtl/core/ptl_cfg.sv]
// Configuration register bank with reset defaults.
// Depends on ptl_pkg.
module ptl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [ptl_pkg::CfgIdxBits-1:0] idx_i,
  input  logic [ptl_pkg::CfgDataBits-1:0] wdata_i,
  output ptl_pkg::cfg_t                  cfg_o
);
  import ptl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_DARK_THRESHOLD: cfg_d.dark_threshold = wdata_i[SampleBits-1:0];
        CFG_DEBOUNCE_MS:    cfg_d.debounce_ms    = wdata_i[MsBits-1:0];
        CFG_AMBER_MS:       cfg_d.amber_ms       = wdata_i[MsBits-1:0];
        CFG_CROSSING_MS:    cfg_d.crossing_ms    = wdata_i[MsBits-1:0];
        CFG_LAMP_LEVEL:     cfg_d.lamp_level     = wdata_i[LampBits-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_threshold <= SampleBits'(2000);
      cfg_q.debounce_ms    <= MsBits'(200);
      cfg_q.amber_ms       <= MsBits'(2000);
      cfg_q.crossing_ms    <= MsBits'(5000);
      cfg_q.lamp_level     <= LampBits'(50);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/ptl_fsm.sv]
// Light phase state machine: debounce, night blinking and day cycle.
// Updates its state once per fired item. Depends on ptl_pkg.
module ptl_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ptl_pkg::item_t   item_i,
  input  ptl_pkg::cfg_t    cfg_i,
  output ptl_pkg::result_t result_o
);
  import ptl_pkg::*;

  phase_e              phase_q, phase_d;
  logic                pending_q, pending_d;
  logic                request_q, request_d;
  logic                blink_q, blink_d;
  logic [TimeBits-1:0] press_t_q, press_t_d;
  logic [TimeBits-1:0] start_t_q, start_t_d;
  logic [TimeBits-1:0] blink_t_q, blink_t_d;

  logic [TimeBits-1:0] press_gap, blink_gap, phase_gap;
  logic                night;

  assign press_gap = item_i.now_ms - press_t_q;
  assign blink_gap = item_i.now_ms - blink_t_q;
  assign night     = item_i.light_sample > cfg_i.dark_threshold;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    request_d = request_q;
    blink_d   = blink_q;
    press_t_d = press_t_q;
    start_t_d = start_t_q;
    blink_t_d = blink_t_q;
    phase_gap = item_i.now_ms - start_t_q;
    result_o  = '0;

    if (item_i.op == OP_BUTTON) begin
      if (press_gap > TimeBits'(cfg_i.debounce_ms)) begin
        pending_d = 1'b1;
        press_t_d = item_i.now_ms;
      end
    end else if (night) begin
      phase_d   = PH_NIGHT;
      pending_d = 1'b0;
      request_d = 1'b0;
      if (blink_gap >= TimeBits'(BlinkMs)) begin
        blink_d   = !blink_q;
        blink_t_d = item_i.now_ms;
      end
      if (blink_d) begin
        result_o.lamp_red   = cfg_i.lamp_level;
        result_o.lamp_green = cfg_i.lamp_level;
      end
    end else begin
      if (phase_q == PH_NIGHT) phase_d = PH_GREEN;
      if (pending_q) begin
        pending_d = 1'b0;
        if (phase_d == PH_GREEN) begin
          request_d = 1'b1;
          phase_d   = PH_YELLOW;
          start_t_d = item_i.now_ms;
          phase_gap = '0;
        end
      end
      unique case (phase_d)
        PH_YELLOW: begin
          result_o.lamp_red   = cfg_i.lamp_level;
          result_o.lamp_green = cfg_i.lamp_level;
          if (phase_gap >= TimeBits'(cfg_i.amber_ms)) begin
            phase_d   = PH_RED;
            start_t_d = item_i.now_ms;
          end
        end
        PH_RED: begin
          result_o.lamp_red = cfg_i.lamp_level;
          if (phase_gap >= TimeBits'(cfg_i.crossing_ms)) begin
            request_d = 1'b0;
            phase_d   = PH_GREEN;
          end
        end
        default: ;
      endcase
    end

    result_o.night_mode      = night;
    result_o.crossing_active = request_d;
    result_o.light_seen      = item_i.light_sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_GREEN;
      pending_q <= 1'b0;
      request_q <= 1'b0;
      blink_q   <= 1'b0;
      press_t_q <= '0;
      start_t_q <= '0;
      blink_t_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      request_q <= request_d;
      blink_q   <= blink_d;
      press_t_q <= press_t_d;
      start_t_q <= start_t_d;
      blink_t_q <= blink_t_d;
    end
  end

endmodule
